@@ src/aci_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the aero coefficient interpolator.
// Depends on nothing; used by aero_coefficient_interpolator.
package aci_pkg;

   // Table geometry: rows of one alpha column
   localparam int unsigned TABLE_ROWS = 28;
   localparam int unsigned ROW_W      = $clog2(TABLE_ROWS);
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ADDR_W     = 12;
   localparam int unsigned DATA_W     = 32;

   // Fixed-point constants (Q16.16)
   localparam int DEG_PER_RAD_Q16 = 3754936;
   localparam int ALPHA_LOW_Q16   = -327680;
   localparam int ALPHA_HIGH_Q16  = 1310720;
   localparam int WEIGHT_MAX      = 8388607;
   localparam int WEIGHT_MIN      = -8388608;
   localparam int ROUND_HALF      = 32768;
   localparam int ALPHA_W         = 22;
   localparam int WEIGHT_W        = 24;

   // Divider and result queue sizing
   localparam int unsigned DIV_STAGES = 32;
   localparam int unsigned RATE_LANES = 4;
   localparam int unsigned FIFO_DEPTH = 32;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH) + 1;

   // Row layout of one column
   localparam int ROW_BREAK        = 0;
   localparam int ROW_STEADY_FIRST = 1;
   localparam int AXES             = 6;

   // Rate lanes
   localparam int LANE_AC = 0;
   localparam int LANE_PB = 1;
   localparam int LANE_QC = 2;
   localparam int LANE_RB = 3;

   // Configuration register index (address bit 2)
   localparam logic CSR_HALF_SPAN  = 1'b0;
   localparam logic CSR_HALF_CHORD = 1'b1;

   typedef logic [TABLE_ROWS-1:0][WORD_W-1:0] coef_row_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RANGE_IN   = 2'd0,
      RANGE_LOW  = 2'd1,
      RANGE_HIGH = 2'd2
   } range_type;

   typedef enum logic [2:0] {
      SRC_BETA,
      SRC_PB,
      SRC_RB,
      SRC_AC,
      SRC_QC,
      SRC_DE,
      SRC_DA,
      SRC_DR
   } src_type;

   // Derivative terms: stored row, multiplying operand, target axis
   localparam int DERIV_COUNT = 21;
   localparam int DERIV_ROW [DERIV_COUNT] = '{
      20,
      7, 8, 9, 22,
      11, 10, 21,
      12, 13, 14, 23, 24,
      15, 16, 25,
      17, 18, 19, 26, 27
   };
   localparam src_type DERIV_SRC [DERIV_COUNT] = '{
      SRC_DE,
      SRC_BETA, SRC_PB, SRC_RB, SRC_DR,
      SRC_QC, SRC_AC, SRC_DE,
      SRC_BETA, SRC_PB, SRC_RB, SRC_DA, SRC_DR,
      SRC_AC, SRC_QC, SRC_DE,
      SRC_BETA, SRC_PB, SRC_RB, SRC_DA, SRC_DR
   };
   localparam int DERIV_AXIS [DERIV_COUNT] = '{
      0,
      1, 1, 1, 1,
      2, 2, 2,
      3, 3, 3, 3, 3,
      4, 4, 4,
      5, 5, 5, 5, 5
   };

endpackage

@@ src/aero_coefficient_interpolator.sv @@
`timescale 1ns / 1ps
// Aero coefficient interpolator: table load, alpha interpolation, derivative build-up.
// Depends on aci_pkg.
//
//  port group | direction | handshake            | carries
//  req_*      | in        | req_valid/req_stall  | load word or flight state
//  rsp_*      | out       | rsp_valid/rsp_stall  | six Q16.16 coefficients, status
//  csr_*      | in/out    | APB write/read       | half_span (0x0), half_chord (0x4)
//
// A request in the capture stage holds req_stall high: the single read port of the
// column memory serves the two column reads (alpha index and index + 1) of each
// compute request. Results pass the rate divider and memory stages before the queue.
// Synchronous reset clears the pipeline valids, queue and counters; the table is
// undefined until loaded. rsp_stall holds the queue head; req_stall rises while
// 32 results are outstanding.
module aero_coefficient_interpolator #(
   parameter int unsigned BREAKPOINTS = 126
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [43:0] req_load_word,
   input  logic [31:0] req_attack_angle,
   input  logic [31:0] req_sideslip,
   input  logic [31:0] req_attack_rate,
   input  logic [31:0] req_roll_rate,
   input  logic [31:0] req_pitch_rate,
   input  logic [31:0] req_yaw_rate,
   input  logic [30:0] req_airspeed,
   input  logic [31:0] req_elevator,
   input  logic [31:0] req_aileron,
   input  logic [31:0] req_rudder,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_coef_x,
   output logic [31:0] rsp_coef_y,
   output logic [31:0] rsp_coef_z,
   output logic [31:0] rsp_coef_roll,
   output logic [31:0] rsp_coef_pitch,
   output logic [31:0] rsp_coef_yaw,
   output logic [1:0]  rsp_range_status,
   output logic        rsp_zero_speed,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned CIDX_W      = (BREAKPOINTS > 2) ? $clog2(BREAKPOINTS) : 1;
   localparam int unsigned STORE_DEPTH = aci_pkg::TABLE_ROWS * BREAKPOINTS;
   localparam int unsigned LADDR_W     = aci_pkg::ADDR_W + 1;

   typedef struct packed {
      aci_pkg::op_type op;
      logic [43:0]     load_word;
      logic [31:0]     attack;
      logic [31:0]     beta;
      logic [31:0]     ar;
      logic [31:0]     pr;
      logic [31:0]     qr;
      logic [31:0]     yr;
      logic [30:0]     speed;
      logic [31:0]     de;
      logic [31:0]     da;
      logic [31:0]     dr;
   } req_type;

   typedef struct packed {
      aci_pkg::op_type               op;
      logic [aci_pkg::ROW_W-1:0]     ld_row;
      logic [CIDX_W-1:0]             ld_col;
      logic                          ld_ok;
      logic [31:0]                   ld_data;
      logic signed [54:0]            alpha_prod;
      logic [aci_pkg::RATE_LANES-1:0][63:0] num;
      logic [31:0]                   den;
      logic                          zero;
      logic [31:0]                   beta;
      logic [31:0]                   de;
      logic [31:0]                   da;
      logic [31:0]                   dr;
   } s2_type;

   typedef struct packed {
      aci_pkg::op_type                 op;
      logic [aci_pkg::ROW_W-1:0]       ld_row;
      logic [CIDX_W-1:0]               ld_col;
      logic                            ld_ok;
      logic [31:0]                     ld_data;
      logic signed [aci_pkg::ALPHA_W-1:0] alpha;
      logic [CIDX_W-1:0]               idx;
      aci_pkg::range_type              status;
      logic [31:0]                     beta;
      logic [31:0]                     de;
      logic [31:0]                     da;
      logic [31:0]                     dr;
      logic                            zero;
      logic [31:0]                     den;
   } side_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] low;
      logic [31:0] quo;
      logic        neg;
      logic        ovf;
   } div_lane_type;

   typedef struct packed {
      side_type                                side;
      logic [aci_pkg::RATE_LANES-1:0][31:0]    scale;
   } mid_type;

   typedef struct packed {
      logic signed [aci_pkg::WEIGHT_W-1:0]     weight;
      logic [aci_pkg::AXES-1:0][32:0]          diff;
      aci_pkg::coef_row_type                   lo;
      logic [aci_pkg::RATE_LANES-1:0][31:0]    scale;
      logic [31:0]                             beta;
      logic [31:0]                             de;
      logic [31:0]                             da;
      logic [31:0]                             dr;
      aci_pkg::range_type                      status;
      logic                                    zero;
   } p1_type;

   typedef struct packed {
      logic [aci_pkg::AXES-1:0][56:0]          interp;
      logic [aci_pkg::DERIV_COUNT-1:0][63:0]   deriv;
      logic [aci_pkg::AXES-1:0][31:0]          c0;
      aci_pkg::range_type                      status;
      logic                                    zero;
   } p2_type;

   typedef struct packed {
      logic [aci_pkg::AXES-1:0][40:0]          interp;
      logic [aci_pkg::DERIV_COUNT-1:0][47:0]   deriv;
      logic [aci_pkg::AXES-1:0][31:0]          c0;
      aci_pkg::range_type                      status;
      logic                                    zero;
   } p3_type;

   typedef struct packed {
      logic [aci_pkg::AXES-1:0][31:0] coef;
      aci_pkg::range_type             status;
      logic                           zero;
   } rsp_item_type;

   // one restoring-division step: one quotient bit
   function automatic div_lane_type div_step(input div_lane_type a, input logic [31:0] den);
      logic [32:0]  trial;
      div_lane_type b;
      b     = a;
      trial = {a.rem, a.low[31]};
      b.low = {a.low[30:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         b.rem = 32'(trial - {1'b0, den});
         b.quo = {a.quo[30:0], 1'b1};
      end else begin
         b.rem = trial[31:0];
         b.quo = {a.quo[30:0], 1'b0};
      end
      return b;
   endfunction

   // signed, saturated rate scale from a finished quotient
   function automatic logic [31:0] scale_out(input div_lane_type a, input logic zero);
      logic [31:0] r;
      if (zero) begin
         r = '0;
      end else if (a.neg) begin
         if (a.ovf || (a.quo > 32'h8000_0000)) r = 32'h8000_0000;
         else r = 32'(-a.quo);
      end else begin
         if (a.ovf || a.quo[31]) r = 32'h7FFF_FFFF;
         else r = a.quo;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   logic [30:0] half_span_ff;
   logic [30:0] half_chord_ff;
   logic        csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_span_ff  <= '0;
         half_chord_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            aci_pkg::CSR_HALF_SPAN:  half_span_ff  <= csr_pwdata[30:0];
            aci_pkg::CSR_HALF_CHORD: half_chord_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         aci_pkg::CSR_HALF_SPAN:  csr_prdata = {1'b0, half_span_ff};
         aci_pkg::CSR_HALF_CHORD: csr_prdata = {1'b0, half_chord_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // request acceptance and outstanding-result credit
   logic                      req_accept;
   logic                      rsp_accept;
   logic [aci_pkg::FIFO_CNT_W-1:0] outstanding_ff;
   logic                      s1_valid_ff;
   req_type                   s1_ff;

   assign req_stall  = s1_valid_ff | (outstanding_ff == aci_pkg::FIFO_CNT_W'(aci_pkg::FIFO_DEPTH));
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         case ({req_accept & (req_op == aci_pkg::OP_COMPUTE), rsp_accept})
            2'b10:   outstanding_ff <= outstanding_ff + 1'b1;
            2'b01:   outstanding_ff <= outstanding_ff - 1'b1;
            default: outstanding_ff <= outstanding_ff;
         endcase
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= req_accept;
      if (req_accept) begin
         s1_ff.op        <= aci_pkg::op_type'(req_op);
         s1_ff.load_word <= req_load_word;
         s1_ff.attack    <= req_attack_angle;
         s1_ff.beta      <= req_sideslip;
         s1_ff.ar        <= req_attack_rate;
         s1_ff.pr        <= req_roll_rate;
         s1_ff.qr        <= req_pitch_rate;
         s1_ff.yr        <= req_yaw_rate;
         s1_ff.speed     <= req_airspeed;
         s1_ff.de        <= req_elevator;
         s1_ff.da        <= req_aileron;
         s1_ff.dr        <= req_rudder;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: degree conversion product, rate numerators, load address split
   logic [LADDR_W-1:0]        ld_rem;
   logic [aci_pkg::ROW_W-1:0] ld_row;
   s2_type                    s2_in;
   s2_type                    s2_ff;
   logic                      s2_valid_ff;

   always_comb begin
      ld_rem = {1'b0, s1_ff.load_word[43:32]};
      ld_row = '0;
      for (int i = aci_pkg::ROW_W - 1; i >= 0; i--) begin
         if (ld_rem >= LADDR_W'(BREAKPOINTS << i)) begin
            ld_rem    = ld_rem - LADDR_W'(BREAKPOINTS << i);
            ld_row[i] = 1'b1;
         end
      end
   end

   always_comb begin
      s2_in.op         = s1_ff.op;
      s2_in.ld_row     = ld_row;
      s2_in.ld_col     = ld_rem[CIDX_W-1:0];
      s2_in.ld_ok      = ({1'b0, s1_ff.load_word[43:32]} < LADDR_W'(STORE_DEPTH));
      s2_in.ld_data    = s1_ff.load_word[31:0];
      s2_in.alpha_prod = $signed(s1_ff.attack)
                       * $signed({1'b0, 22'(aci_pkg::DEG_PER_RAD_Q16)});
      s2_in.num[aci_pkg::LANE_AC] = 64'($signed(s1_ff.ar) * $signed({1'b0, half_chord_ff}));
      s2_in.num[aci_pkg::LANE_PB] = 64'($signed(s1_ff.pr) * $signed({1'b0, half_span_ff}));
      s2_in.num[aci_pkg::LANE_QC] = 64'($signed(s1_ff.qr) * $signed({1'b0, half_chord_ff}));
      s2_in.num[aci_pkg::LANE_RB] = 64'($signed(s1_ff.yr) * $signed({1'b0, half_span_ff}));
      s2_in.den        = {s1_ff.speed, 1'b0};
      s2_in.zero       = (s1_ff.speed == '0);
      s2_in.beta       = s1_ff.beta;
      s2_in.de         = s1_ff.de;
      s2_in.da         = s1_ff.da;
      s2_in.dr         = s1_ff.dr;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_ff <= s2_in;
   end

   // ------------------------------------------------------------------
   // stage 2: round and clamp alpha, column index, divider setup
   logic signed [54:0]                alpha_full;
   logic signed [aci_pkg::ALPHA_W-1:0] alpha_clamp;
   aci_pkg::range_type                alpha_status;
   logic [20:0]                       alpha_off;
   logic [23:0]                       alpha_off5;
   logic [7:0]                        idx_raw;
   logic [CIDX_W-1:0]                 idx_cap;
   side_type                          side_in;
   div_lane_type                      lane_in [aci_pkg::RATE_LANES];
   logic [63:0]                       num_mag [aci_pkg::RATE_LANES];

   always_comb begin
      alpha_full = (s2_ff.alpha_prod + 55'(aci_pkg::ROUND_HALF)) >>> 16;
      if (alpha_full < 55'(aci_pkg::ALPHA_LOW_Q16)) begin
         alpha_clamp  = aci_pkg::ALPHA_W'(aci_pkg::ALPHA_LOW_Q16);
         alpha_status = aci_pkg::RANGE_LOW;
      end else if (alpha_full > 55'(aci_pkg::ALPHA_HIGH_Q16)) begin
         alpha_clamp  = aci_pkg::ALPHA_W'(aci_pkg::ALPHA_HIGH_Q16);
         alpha_status = aci_pkg::RANGE_HIGH;
      end else begin
         alpha_clamp  = alpha_full[aci_pkg::ALPHA_W-1:0];
         alpha_status = aci_pkg::RANGE_IN;
      end
      alpha_off  = 21'(alpha_clamp - aci_pkg::ALPHA_W'(aci_pkg::ALPHA_LOW_Q16));
      alpha_off5 = 24'(alpha_off) * 24'd5;
      idx_raw    = alpha_off5[23:16];
      // cap so the top of the range uses the last segment
      if (32'(idx_raw) > 32'(BREAKPOINTS - 2)) idx_cap = CIDX_W'(BREAKPOINTS - 2);
      else                                     idx_cap = idx_raw[CIDX_W-1:0];
   end

   always_comb begin
      side_in.op      = s2_ff.op;
      side_in.ld_row  = s2_ff.ld_row;
      side_in.ld_col  = s2_ff.ld_col;
      side_in.ld_ok   = s2_ff.ld_ok;
      side_in.ld_data = s2_ff.ld_data;
      side_in.alpha   = alpha_clamp;
      side_in.idx     = idx_cap;
      side_in.status  = alpha_status;
      side_in.beta    = s2_ff.beta;
      side_in.de      = s2_ff.de;
      side_in.da      = s2_ff.da;
      side_in.dr      = s2_ff.dr;
      side_in.zero    = s2_ff.zero;
      side_in.den     = s2_ff.den;
      for (int l = 0; l < aci_pkg::RATE_LANES; l++) begin
         num_mag[l]     = s2_ff.num[l][63] ? 64'(-s2_ff.num[l]) : s2_ff.num[l];
         lane_in[l].neg = s2_ff.num[l][63];
         lane_in[l].ovf = (num_mag[l][63:32] >= s2_ff.den);
         lane_in[l].rem = num_mag[l][63:32];
         lane_in[l].low = num_mag[l][31:0];
         lane_in[l].quo = '0;
      end
   end

   // ------------------------------------------------------------------
   // rate divider: one quotient bit per stage, four lanes share the divisor
   div_lane_type                  dl_ff    [aci_pkg::DIV_STAGES+1][aci_pkg::RATE_LANES];
   side_type                      dside_ff [aci_pkg::DIV_STAGES+1];
   logic [aci_pkg::DIV_STAGES:0]  dvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) dvalid_ff <= '0;
      else       dvalid_ff <= {dvalid_ff[aci_pkg::DIV_STAGES-1:0], s2_valid_ff};
   end

   always_ff @(posedge clock) begin
      dside_ff[0] <= side_in;
      for (int l = 0; l < aci_pkg::RATE_LANES; l++) dl_ff[0][l] <= lane_in[l];
      for (int j = 0; j < aci_pkg::DIV_STAGES; j++) begin
         dside_ff[j+1] <= dside_ff[j];
         for (int l = 0; l < aci_pkg::RATE_LANES; l++) begin
            dl_ff[j+1][l] <= div_step(dl_ff[j][l], dside_ff[j].den);
         end
      end
   end

   // ------------------------------------------------------------------
   // memory stages: load write or first column read, then second column read
   mid_type               m_in;
   mid_type               m_ff;
   mid_type               m2_ff;
   mid_type               m3_ff;
   logic                  m_valid_ff;
   logic                  m2_valid_ff;
   logic                  m3_valid_ff;
   aci_pkg::coef_row_type store_mem [BREAKPOINTS];
   aci_pkg::coef_row_type mem_q_ff;
   aci_pkg::coef_row_type lo_ff;
   logic [CIDX_W-1:0]     rd_col;
   logic                  mem_wr;

   always_comb begin
      m_in.side = dside_ff[aci_pkg::DIV_STAGES];
      for (int l = 0; l < aci_pkg::RATE_LANES; l++) begin
         m_in.scale[l] = scale_out(dl_ff[aci_pkg::DIV_STAGES][l],
                                   dside_ff[aci_pkg::DIV_STAGES].zero);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else begin
         m_valid_ff  <= dvalid_ff[aci_pkg::DIV_STAGES];
         m2_valid_ff <= m_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
      m_ff  <= m_in;
      m2_ff <= m_ff;
      m3_ff <= m2_ff;
   end

   // second read goes to the next column; req_stall keeps requests from arriving back to back
   assign rd_col = m2_valid_ff ? CIDX_W'(m2_ff.side.idx + 1'b1) : m_ff.side.idx;
   assign mem_wr = m_valid_ff & (m_ff.side.op == aci_pkg::OP_LOAD) & m_ff.side.ld_ok;

   always_ff @(posedge clock) begin
      if (mem_wr) store_mem[m_ff.side.ld_col][m_ff.side.ld_row] <= m_ff.side.ld_data;
      mem_q_ff <= store_mem[rd_col];
   end

   // hold the first column while the second is read
   always_ff @(posedge clock) begin
      if (m2_valid_ff) lo_ff <= mem_q_ff;
   end

   // ------------------------------------------------------------------
   // stage M3: interpolation weight and steady-coefficient slopes
   logic signed [32:0] wdiff;
   logic signed [35:0] w5;
   p1_type             p1_in;
   p1_type             p1_ff;
   logic               p1_valid_ff;

   always_comb begin
      wdiff = 33'(m3_ff.side.alpha) - 33'($signed(lo_ff[aci_pkg::ROW_BREAK]));
      w5    = 36'(wdiff) * 36'sd5;
      if (w5 > 36'(aci_pkg::WEIGHT_MAX))      p1_in.weight = aci_pkg::WEIGHT_W'(aci_pkg::WEIGHT_MAX);
      else if (w5 < 36'(aci_pkg::WEIGHT_MIN)) p1_in.weight = aci_pkg::WEIGHT_W'(aci_pkg::WEIGHT_MIN);
      else                                    p1_in.weight = w5[aci_pkg::WEIGHT_W-1:0];
      for (int k = 0; k < aci_pkg::AXES; k++) begin
         p1_in.diff[k] = 33'($signed(mem_q_ff[aci_pkg::ROW_STEADY_FIRST+k]))
                       - 33'($signed(lo_ff[aci_pkg::ROW_STEADY_FIRST+k]));
      end
      p1_in.lo     = lo_ff;
      p1_in.scale  = m3_ff.scale;
      p1_in.beta   = m3_ff.side.beta;
      p1_in.de     = m3_ff.side.de;
      p1_in.da     = m3_ff.side.da;
      p1_in.dr     = m3_ff.side.dr;
      p1_in.status = m3_ff.side.status;
      p1_in.zero   = m3_ff.side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else       p1_valid_ff <= m3_valid_ff & (m3_ff.side.op == aci_pkg::OP_COMPUTE);
      p1_ff <= p1_in;
   end

   // ------------------------------------------------------------------
   // stage P1: all products
   p2_type      p2_in;
   p2_type      p2_ff;
   logic        p2_valid_ff;
   logic [31:0] opnd [aci_pkg::DERIV_COUNT];

   always_comb begin
      for (int k = 0; k < aci_pkg::DERIV_COUNT; k++) begin
         case (aci_pkg::DERIV_SRC[k])
            aci_pkg::SRC_BETA: opnd[k] = p1_ff.beta;
            aci_pkg::SRC_PB:   opnd[k] = p1_ff.scale[aci_pkg::LANE_PB];
            aci_pkg::SRC_RB:   opnd[k] = p1_ff.scale[aci_pkg::LANE_RB];
            aci_pkg::SRC_AC:   opnd[k] = p1_ff.scale[aci_pkg::LANE_AC];
            aci_pkg::SRC_QC:   opnd[k] = p1_ff.scale[aci_pkg::LANE_QC];
            aci_pkg::SRC_DE:   opnd[k] = p1_ff.de;
            aci_pkg::SRC_DA:   opnd[k] = p1_ff.da;
            aci_pkg::SRC_DR:   opnd[k] = p1_ff.dr;
            default:           opnd[k] = '0;
         endcase
         p2_in.deriv[k] = 64'($signed(p1_ff.lo[aci_pkg::DERIV_ROW[k]]) * $signed(opnd[k]));
      end
      for (int k = 0; k < aci_pkg::AXES; k++) begin
         p2_in.interp[k] = 57'($signed(p1_ff.diff[k]) * $signed(p1_ff.weight));
         p2_in.c0[k]     = p1_ff.lo[aci_pkg::ROW_STEADY_FIRST+k];
      end
      p2_in.status = p1_ff.status;
      p2_in.zero   = p1_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) p2_valid_ff <= 1'b0;
      else       p2_valid_ff <= p1_valid_ff;
      p2_ff <= p2_in;
   end

   // ------------------------------------------------------------------
   // stage P2: round every product to Q16.16, half up
   p3_type p3_in;
   p3_type p3_ff;
   logic   p3_valid_ff;

   always_comb begin
      for (int k = 0; k < aci_pkg::DERIV_COUNT; k++) begin
         p3_in.deriv[k] = 48'(($signed(p2_ff.deriv[k]) + 64'(aci_pkg::ROUND_HALF)) >>> 16);
      end
      for (int k = 0; k < aci_pkg::AXES; k++) begin
         p3_in.interp[k] = 41'(($signed(p2_ff.interp[k]) + 57'(aci_pkg::ROUND_HALF)) >>> 16);
      end
      p3_in.c0     = p2_ff.c0;
      p3_in.status = p2_ff.status;
      p3_in.zero   = p2_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) p3_valid_ff <= 1'b0;
      else       p3_valid_ff <= p2_valid_ff;
      p3_ff <= p3_in;
   end

   // ------------------------------------------------------------------
   // stage P3: sum terms per axis and saturate
   logic signed [51:0] axis_sum [aci_pkg::AXES];
   rsp_item_type       push_item;

   always_comb begin
      for (int a = 0; a < aci_pkg::AXES; a++) begin
         axis_sum[a] = 52'($signed(p3_ff.c0[a])) + 52'($signed(p3_ff.interp[a]));
         for (int k = 0; k < aci_pkg::DERIV_COUNT; k++) begin
            if (aci_pkg::DERIV_AXIS[k] == a) begin
               axis_sum[a] = axis_sum[a] + 52'($signed(p3_ff.deriv[k]));
            end
         end
         if (axis_sum[a] > 52'sh7FFF_FFFF)        push_item.coef[a] = 32'h7FFF_FFFF;
         else if (axis_sum[a] < -52'sh8000_0000)  push_item.coef[a] = 32'h8000_0000;
         else                                     push_item.coef[a] = axis_sum[a][31:0];
      end
      push_item.status = p3_ff.status;
      push_item.zero   = p3_ff.zero;
   end

   // ------------------------------------------------------------------
   // result queue
   rsp_item_type                   fifo_mem [aci_pkg::FIFO_DEPTH];
   logic [aci_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [aci_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [aci_pkg::FIFO_CNT_W-1:0] fifo_cnt_ff;
   rsp_item_type                   head;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (p3_valid_ff) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_accept)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({p3_valid_ff, rsp_accept})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + 1'b1;
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - 1'b1;
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (p3_valid_ff) fifo_mem[wr_ptr_ff] <= push_item;
   end

   assign head             = fifo_mem[rd_ptr_ff];
   assign rsp_valid        = (fifo_cnt_ff != '0);
   assign rsp_coef_x       = head.coef[0];
   assign rsp_coef_y       = head.coef[1];
   assign rsp_coef_z       = head.coef[2];
   assign rsp_coef_roll    = head.coef[3];
   assign rsp_coef_pitch   = head.coef[4];
   assign rsp_coef_yaw     = head.coef[5];
   assign rsp_range_status = head.status;
   assign rsp_zero_speed   = head.zero;

   // ------------------------------------------------------------------
   // checks
   a_credit_bound : assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= aci_pkg::FIFO_CNT_W'(aci_pkg::FIFO_DEPTH))
      else $error("outstanding results exceed queue depth");

   a_request_spacing : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> !s1_valid_ff)
      else $error("requests closer than two cycles");

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      p3_valid_ff |-> (fifo_cnt_ff < aci_pkg::FIFO_CNT_W'(aci_pkg::FIFO_DEPTH)))
      else $error("result pushed into full queue");

   a_next_column : assert property (@(posedge clock) disable iff (reset)
      (m2_valid_ff && (m2_ff.side.op == aci_pkg::OP_COMPUTE))
         |-> (rd_col == CIDX_W'($past(rd_col) + 1'b1)))
      else $error("second column read is not the next column");

endmodule
